// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the bus decoder
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/mbad_pkg.sv =====
`timescale 1ns / 1ps
// types and constants of the memory bus address decoder
// no dependencies; imported by every module of the block but mbad_bank
package mbad_pkg;

   localparam int LANES       = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int SIZE_REG_W  = 17;

   localparam logic [1:0] REQ_READ    = 2'd0;
   localparam logic [1:0] REQ_WRITE   = 2'd1;
   localparam logic [1:0] REQ_PRELOAD = 2'd2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BUS   = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RAM_START   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_START   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UART_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_START = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_START  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UART_BYTES  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_BYTES = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_BYTES  = 3'd7;

   localparam logic [31:0]           RST_RAM_START   = 32'h0000_0000;
   localparam logic [31:0]           RST_ROM_START   = 32'h1000_0000;
   localparam logic [31:0]           RST_UART_START  = 32'h2000_0000;
   localparam logic [31:0]           RST_TIMER_START = 32'h2000_1000;
   localparam logic [31:0]           RST_DISK_START  = 32'h2000_2000;
   localparam logic [SIZE_REG_W-1:0] RST_PER_BYTES   = 17'd256;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  access_size;
      logic [31:0] address;
      logic [31:0] write_data;
   } mbad_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } mbad_rsp_type;

   typedef struct packed {
      logic [31:0]           ram_start;
      logic [31:0]           rom_start;
      logic [31:0]           uart_start;
      logic [31:0]           timer_start;
      logic [31:0]           disk_start;
      logic [SIZE_REG_W-1:0] uart_bytes;
      logic [SIZE_REG_W-1:0] timer_bytes;
      logic [SIZE_REG_W-1:0] disk_bytes;
   } mbad_cfg_type;

   // decoded access waiting for the memory side
   typedef struct packed {
      logic             rd;
      logic [LANES-1:0] ram_sel;
      logic [LANES-1:0] rom_sel;
      logic [31:0]      address;
      logic [31:0]      write_data;
      logic [1:0]       status;
   } mbad_cmd_type;

endpackage

// ===== src/memory_bus_address_decoder_unit.sv =====
`timescale 1ns / 1ps
// top level of the memory bus address decoder: config registers, front end, queue, memory side
// depends on mbad_pkg, mbad_front, mbad_queue, mbad_back and assert_macros.svh
`include "assert_macros.svh"
// usage
// - req channel: one bus access per item (read, write or rom preload of 1, 2 or 4 bytes);
//   an item is taken at a clock edge with req_valid high and req_stall low
// - rsp channel: exactly one item per access, in order: read data and status
//   (ok, bus error, alignment error); read data is zero for writes and for any error
// - csr port: csr_we writes register csr_index with csr_wdata; write only
//   while no access is in flight
// - flow: an accepted item enters the queue, leaves its head for the banks once the result
//   register is free or being taken, and rsp_valid rises with its result as it is issued
// - throughput: one item per cycle while rsp_stall stays low; every byte lane of ram and
//   rom has its own bank, so one access of up to four bytes reaches all its bytes at once
// - stall: the result register holds while rsp_stall is high; the two-entry queue keeps
//   taking items until it is full, then req_stall rises
// - reset: window bases and sizes return to their defaults, queue and result register
//   empty; ram and rom contents are not cleared and are undefined until written
module memory_bus_address_decoder_unit #(
   parameter int RAM_BYTES = 65536,
   parameter int ROM_BYTES = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mbad_pkg::mbad_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mbad_pkg::mbad_rsp_type              rsp_payload,
   input  logic                                csr_we,
   input  logic [mbad_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_wdata
);
   import mbad_pkg::*;

   mbad_cfg_type cfg_ff, cfg_in;
   logic         q_full, q_push, q_pop, q_valid;
   mbad_cmd_type push_cmd, head_cmd;

   // configuration registers, narrow sizes keep the low bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RAM_START:   cfg_in.ram_start   = csr_wdata;
            CSR_ROM_START:   cfg_in.rom_start   = csr_wdata;
            CSR_UART_START:  cfg_in.uart_start  = csr_wdata;
            CSR_TIMER_START: cfg_in.timer_start = csr_wdata;
            CSR_DISK_START:  cfg_in.disk_start  = csr_wdata;
            CSR_UART_BYTES:  cfg_in.uart_bytes  = csr_wdata[SIZE_REG_W-1:0];
            CSR_TIMER_BYTES: cfg_in.timer_bytes = csr_wdata[SIZE_REG_W-1:0];
            CSR_DISK_BYTES:  cfg_in.disk_bytes  = csr_wdata[SIZE_REG_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ram_start   <= RST_RAM_START;
         cfg_ff.rom_start   <= RST_ROM_START;
         cfg_ff.uart_start  <= RST_UART_START;
         cfg_ff.timer_start <= RST_TIMER_START;
         cfg_ff.disk_start  <= RST_DISK_START;
         cfg_ff.uart_bytes  <= RST_PER_BYTES;
         cfg_ff.timer_bytes <= RST_PER_BYTES;
         cfg_ff.disk_bytes  <= RST_PER_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode every lane at accept time
   mbad_front #(
      .RAM_BYTES (RAM_BYTES),
      .ROM_BYTES (ROM_BYTES)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .push        (q_push),
      .push_cmd    (push_cmd)
   );

   // decouples intake from the banks and the result register
   mbad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   // bank access and result register
   mbad_back #(
      .RAM_BYTES (RAM_BYTES),
      .ROM_BYTES (ROM_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (q_valid),
      .head_cmd    (head_cmd),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // an accepted item is in the queue on the next cycle
   `ASSERT_NEXT(a_accept_queued, clock, reset, req_valid && !req_stall, q_valid, "accepted item lost before the queue")
   // any error result carries zero read data
   `ASSERT_SAME(a_err_zero_data, clock, reset, rsp_valid && (rsp_payload.status != ST_OK), rsp_payload.read_data == 32'd0, "error result with read data")
   // only the three defined status codes leave the block
   `ASSERT_SAME(a_status_code, clock, reset, rsp_valid, (rsp_payload.status == ST_OK) || (rsp_payload.status == ST_BUS) || (rsp_payload.status == ST_ALIGN), "undefined status code")

endmodule

// ===== src/mbad_bank.sv =====
`timescale 1ns / 1ps
// one byte-wide bank of the ram or rom store, single port, registered read
// uses nothing from the package
module mbad_bank #(
   parameter  int ROWS  = 16384,
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [ROW_W-1:0] row,
   input  logic [7:0]       wdata,
   output logic [7:0]       rdata
);

   logic [7:0] mem [ROWS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[row] <= wdata;
      end
   end

   // read data only moves on a read, so it holds while the result waits
   always_ff @(posedge clock) begin
      if (en && !we) begin
         rdata_ff <= mem[row];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/mbad_front.sv =====
`timescale 1ns / 1ps
// front end: accepts bus accesses and decodes every byte lane against the windows
// depends on mbad_pkg
module mbad_front #(
   parameter int RAM_BYTES = 65536,
   parameter int ROM_BYTES = 65536
) (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mbad_pkg::mbad_req_type req_payload,
   input  mbad_pkg::mbad_cfg_type cfg,
   input  logic                 q_full,
   output logic                 push,
   output mbad_pkg::mbad_cmd_type push_cmd
);
   import mbad_pkg::*;

   localparam logic [32:0] RAM_SPAN = 33'(RAM_BYTES);
   localparam logic [32:0] ROM_SPAN = 33'(ROM_BYTES);

   // base <= a < base + size, no wrap at the top of the address space
   function automatic logic in_window(input logic [31:0] a, input logic [31:0] base,
                                      input logic [32:0] size);
      return (a >= base) && ({1'b0, a} < ({1'b0, base} + size));
   endfunction

   assign push      = req_valid && !q_full;
   assign req_stall = q_full;

   always_comb begin
      logic [31:0]      lane_addr;
      logic             in_ram, in_rom, in_per;
      logic             bad, ram_l, rom_l, alive, fault, misalign, is_read;
      logic [2:0]       nbytes;
      logic [LANES-1:0] ram_sel, rom_sel;

      case (req_payload.access_size)
         SIZE_BYTE: begin
            nbytes   = 3'd1;
            misalign = 1'b0;
         end
         SIZE_HALF: begin
            nbytes   = 3'd2;
            misalign = req_payload.address[0];
         end
         default: begin
            nbytes   = 3'd4;
            misalign = |req_payload.address[1:0];
         end
      endcase

      is_read = !(req_payload.req_type == REQ_WRITE || req_payload.req_type == REQ_PRELOAD);
      alive   = 1'b1;
      fault   = 1'b0;
      ram_sel = '0;
      rom_sel = '0;

      for (int i = 0; i < LANES; i++) begin
         // aligned access: lane address is the base address with the lane in the low bits
         lane_addr = {req_payload.address[31:2], req_payload.address[1:0] | 2'(i)};
         in_ram    = in_window(lane_addr, cfg.ram_start, RAM_SPAN);
         in_rom    = in_window(lane_addr, cfg.rom_start, ROM_SPAN);
         in_per    = in_window(lane_addr, cfg.uart_start, {16'd0, cfg.uart_bytes})
                  || in_window(lane_addr, cfg.timer_start, {16'd0, cfg.timer_bytes})
                  || in_window(lane_addr, cfg.disk_start, {16'd0, cfg.disk_bytes});
         case (req_payload.req_type)
            REQ_PRELOAD: begin
               bad   = !in_rom;
               ram_l = 1'b0;
               rom_l = in_rom;
            end
            REQ_WRITE: begin
               bad   = !(in_ram || in_rom || in_per) || (!in_ram && in_rom);
               ram_l = in_ram;
               rom_l = 1'b0;
            end
            default: begin
               bad   = !(in_ram || in_rom || in_per);
               ram_l = in_ram;
               rom_l = !in_ram && in_rom;
            end
         endcase
         if ((3'(i) < nbytes) && alive) begin
            if (bad) begin
               fault = 1'b1;
               alive = 1'b0;
            end else begin
               ram_sel[i] = ram_l;
               rom_sel[i] = rom_l;
            end
         end
      end

      // a misaligned access or failed read touches nothing; a failed write or preload keeps the lanes before the fault
      if (misalign || (is_read && fault)) begin
         ram_sel = '0;
         rom_sel = '0;
      end

      push_cmd.rd         = is_read;
      push_cmd.ram_sel    = ram_sel;
      push_cmd.rom_sel    = rom_sel;
      push_cmd.address    = req_payload.address;
      push_cmd.write_data = req_payload.write_data;
      push_cmd.status     = misalign ? ST_ALIGN : (fault ? ST_BUS : ST_OK);
   end

endmodule

// ===== src/mbad_queue.sv =====
`timescale 1ns / 1ps
// short fifo of decoded accesses between front end and memory side
// depends on mbad_pkg
module mbad_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mbad_pkg::mbad_cmd_type push_cmd,
   input  logic                   pop,
   output logic                   full,
   output logic                   head_valid,
   output mbad_pkg::mbad_cmd_type head_cmd
);
   import mbad_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mbad_cmd_type     entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/mbad_back.sv =====
`timescale 1ns / 1ps
// memory side: drives the byte banks of ram and rom and holds the result register
// depends on mbad_pkg and mbad_bank
module mbad_back #(
   parameter int RAM_BYTES = 65536,
   parameter int ROM_BYTES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mbad_pkg::mbad_cfg_type cfg,
   input  logic                   head_valid,
   input  mbad_pkg::mbad_cmd_type head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mbad_pkg::mbad_rsp_type rsp_payload
);
   import mbad_pkg::*;

   localparam int RAM_IW   = $clog2(RAM_BYTES);
   localparam int ROM_IW   = $clog2(ROM_BYTES);
   localparam int RAM_ROWS = (RAM_BYTES + LANES - 1) / LANES;
   localparam int ROM_ROWS = (ROM_BYTES + LANES - 1) / LANES;
   localparam int RAM_RW   = (RAM_ROWS > 1) ? $clog2(RAM_ROWS) : 1;
   localparam int ROM_RW   = (ROM_ROWS > 1) ? $clog2(ROM_ROWS) : 1;

   logic              issue;
   logic [RAM_IW-1:0] ram_idx [LANES];
   logic [ROM_IW-1:0] rom_idx [LANES];

   logic              ram_en [LANES];
   logic [RAM_RW-1:0] ram_row [LANES];
   logic [7:0]        ram_wd  [LANES];
   logic [7:0]        ram_q   [LANES];
   logic              rom_en [LANES];
   logic [ROM_RW-1:0] rom_row [LANES];
   logic [7:0]        rom_wd  [LANES];
   logic [7:0]        rom_q   [LANES];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            status_ff;
   logic [LANES-1:0]      lane_ram_ff, lane_rom_ff;
   logic [LANES-1:0][1:0] lane_bank_ff;

   assign issue = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop   = issue;

   // offsets into the stores; a selected lane always lies inside its window
   always_comb begin
      logic [31:0] lane_addr;
      for (int i = 0; i < LANES; i++) begin
         lane_addr  = {head_cmd.address[31:2], head_cmd.address[1:0] | 2'(i)};
         ram_idx[i] = RAM_IW'(lane_addr - cfg.ram_start);
         rom_idx[i] = ROM_IW'(lane_addr - cfg.rom_start);
      end
   end

   // consecutive offsets land in distinct banks, so each bank serves at most one lane
   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         ram_en[b]  = 1'b0;
         ram_row[b] = '0;
         ram_wd[b]  = '0;
         rom_en[b]  = 1'b0;
         rom_row[b] = '0;
         rom_wd[b]  = '0;
         for (int i = 0; i < LANES; i++) begin
            if (issue && head_cmd.ram_sel[i] && (ram_idx[i][1:0] == b[1:0])) begin
               ram_en[b]  = 1'b1;
               ram_row[b] = RAM_RW'(ram_idx[i] >> 2);
               ram_wd[b]  = head_cmd.write_data[8*i +: 8];
            end
            if (issue && head_cmd.rom_sel[i] && (rom_idx[i][1:0] == b[1:0])) begin
               rom_en[b]  = 1'b1;
               rom_row[b] = ROM_RW'(rom_idx[i] >> 2);
               rom_wd[b]  = head_cmd.write_data[8*i +: 8];
            end
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_bank
      mbad_bank #(.ROWS(RAM_ROWS)) u_ram_bank (
         .clock (clock),
         .en    (ram_en[g]),
         .we    (!head_cmd.rd),
         .row   (ram_row[g]),
         .wdata (ram_wd[g]),
         .rdata (ram_q[g])
      );
      mbad_bank #(.ROWS(ROM_ROWS)) u_rom_bank (
         .clock (clock),
         .en    (rom_en[g]),
         .we    (!head_cmd.rd),
         .row   (rom_row[g]),
         .wdata (rom_wd[g]),
         .rdata (rom_q[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (issue) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // lane steering for the read data, registered at issue along with the bank reads
   always_ff @(posedge clock) begin
      if (issue) begin
         status_ff   <= head_cmd.status;
         lane_ram_ff <= head_cmd.rd ? head_cmd.ram_sel : '0;
         lane_rom_ff <= head_cmd.rd ? head_cmd.rom_sel : '0;
         for (int i = 0; i < LANES; i++) begin
            lane_bank_ff[i] <= head_cmd.ram_sel[i] ? ram_idx[i][1:0] : rom_idx[i][1:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (lane_ram_ff[i]) begin
            rsp_payload.read_data[8*i +: 8] = ram_q[lane_bank_ff[i]];
         end else if (lane_rom_ff[i]) begin
            rsp_payload.read_data[8*i +: 8] = rom_q[lane_bank_ff[i]];
         end else begin
            rsp_payload.read_data[8*i +: 8] = 8'd0;
         end
      end
      rsp_payload.status = status_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== tb/memory_bus_address_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the memory bus address decoder unit
// depends on mbad_pkg and the rtl of the block; carries its own decoder predictor
module memory_bus_address_decoder_unit_test;
   import mbad_pkg::*;

   // codes the package leaves out
   localparam logic [1:0] REQ_ODD   = 2'd3;   // unknown type, decoded as a read
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_ODD  = 2'd3;   // unknown size, decoded as a word

   localparam logic [16:0] STORE_SPAN  = 17'h1_0000;  // ram and rom both hold 64 KiB
   localparam int          SCRIPT_LEN  = 29;
   localparam int          PHASES      = 6;
   localparam int          PER_PHASE   = 290;
   localparam int          QUIET_LIMIT = 2000;        // cycles without any handshake
   localparam int          TAIL_CYCLES = 4;           // idle cycles before the verdict

   typedef enum logic [2:0] {WIN_RAM, WIN_ROM, WIN_UART, WIN_TIMER, WIN_DISK, WIN_NONE}
      window_kind_type;

   // one row of the directed script: a register write or an access
   typedef struct packed {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] csr_sel;
      logic [31:0]          csr_value;
      mbad_req_type         access;
      bit                   typed;
      mbad_rsp_type         want;
   } script_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   mbad_req_type         req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   mbad_rsp_type         rsp_payload;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   // predictor state: window registers and both byte stores with their written flags
   mbad_cfg_type windows;
   logic [7:0]   ram_image [0:65535];
   logic [7:0]   rom_image [0:65535];
   bit           ram_filled [0:65535];
   bit           rom_filled [0:65535];

   mbad_rsp_type pending_bus_results [$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int unsigned  req_gap_pct = 0;
   int unsigned  rsp_stall_pct = 0;

   memory_bus_address_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned lane_count(logic [1:0] size);
      if (size == SIZE_BYTE) return 1;
      if (size == SIZE_HALF) return 2;
      return 4;
   endfunction

   // membership without wrap: a window running past the top of memory is clipped there
   function automatic bit in_window(logic [31:0] a, logic [31:0] base, logic [16:0] span);
      return a >= base && {1'b0, a} < {1'b0, base} + {16'd0, span};
   endfunction

   // priority order: ram, rom, uart, timer, disk
   function automatic window_kind_type window_of(logic [31:0] a);
      if (in_window(a, windows.ram_start, STORE_SPAN)) return WIN_RAM;
      if (in_window(a, windows.rom_start, STORE_SPAN)) return WIN_ROM;
      if (in_window(a, windows.uart_start, windows.uart_bytes)) return WIN_UART;
      if (in_window(a, windows.timer_start, windows.timer_bytes)) return WIN_TIMER;
      if (in_window(a, windows.disk_start, windows.disk_bytes)) return WIN_DISK;
      return WIN_NONE;
   endfunction

   // walks the bytes of one access in little-endian order, updates the stores and
   // returns the result the block owes for it
   function automatic mbad_rsp_type decode_bus_access(mbad_req_type item);
      mbad_rsp_type    rsp;
      logic [31:0]     a;
      logic [7:0]      lane;
      logic [15:0]     slot;
      window_kind_type win;
      int unsigned     count;
      bit              stop;
      rsp = '0;
      rsp.status = ST_OK;
      count = lane_count(item.access_size);
      stop = 1'b0;
      if ((item.address & (count - 1)) != 0) begin
         rsp.status = ST_ALIGN;
         stop = 1'b1;
      end
      for (int i = 0; i < count && !stop; i++) begin
         a = item.address + i;
         lane = item.write_data[8*i +: 8];
         if (item.req_type == REQ_PRELOAD) begin
            // preload looks at the rom window alone, even under an overlapping ram
            if (!in_window(a, windows.rom_start, STORE_SPAN)) begin
               rsp.status = ST_BUS;
               stop = 1'b1;
            end else begin
               slot = 16'(a - windows.rom_start);
               rom_image[slot] = lane;
               rom_filled[slot] = 1'b1;
            end
         end else begin
            win = window_of(a);
            if (win == WIN_NONE || (item.req_type == REQ_WRITE && win == WIN_ROM)) begin
               // earlier bytes of a write stay written
               rsp.status = ST_BUS;
               stop = 1'b1;
            end else if (item.req_type == REQ_WRITE) begin
               if (win == WIN_RAM) begin
                  slot = 16'(a - windows.ram_start);
                  ram_image[slot] = lane;
                  ram_filled[slot] = 1'b1;
               end
            end else if (win == WIN_RAM) begin
               rsp.read_data[8*i +: 8] = ram_image[16'(a - windows.ram_start)];
            end else if (win == WIN_ROM) begin
               rsp.read_data[8*i +: 8] = rom_image[16'(a - windows.rom_start)];
            end
         end
      end
      if (rsp.status != ST_OK || item.req_type == REQ_WRITE || item.req_type == REQ_PRELOAD)
         rsp.read_data = '0;
      return rsp;
   endfunction

   // false when a read would touch a store byte that was never written
   function automatic bit reads_defined(mbad_req_type item);
      logic [31:0]     a;
      window_kind_type win;
      int unsigned     count;
      count = lane_count(item.access_size);
      if (item.req_type == REQ_WRITE || item.req_type == REQ_PRELOAD) return 1'b1;
      if ((item.address & (count - 1)) != 0) return 1'b1;
      for (int i = 0; i < count; i++) begin
         a = item.address + i;
         win = window_of(a);
         if (win == WIN_NONE) return 1'b1;
         if (win == WIN_RAM && !ram_filled[16'(a - windows.ram_start)]) return 1'b0;
         if (win == WIN_ROM && !rom_filled[16'(a - windows.rom_start)]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // addresses cluster on small pools inside each window and on window edges, so
   // reads land on bytes that earlier writes and preloads filled
   function automatic logic [31:0] pick_address(logic [1:0] size);
      logic [31:0] base;
      logic [31:0] span;
      logic [31:0] a;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            base = windows.ram_start;
            span = 32'(STORE_SPAN);
         end
         3, 4: begin
            base = windows.rom_start;
            span = 32'(STORE_SPAN);
         end
         5: begin
            base = windows.uart_start;
            span = 32'(windows.uart_bytes);
         end
         6: begin
            base = windows.timer_start;
            span = 32'(windows.timer_bytes);
         end
         7: begin
            base = windows.disk_start;
            span = 32'(windows.disk_bytes);
         end
         default: begin
            base = $urandom();
            span = 32'd256;
         end
      endcase
      case ($urandom_range(0, 3))
         0: a = base + $urandom_range(0, 63);
         1: a = base + span - 64 + $urandom_range(0, 71);   // top end and just past it
         2: a = base + 32'h1000 + $urandom_range(0, 255);
         default: a = base - 8 + $urandom_range(0, 15);     // around the start, just below it and just above it
      endcase
      // mostly aligned, the rest left as it falls
      if ($urandom_range(0, 99) < 88) begin
         if (size == SIZE_HALF) a[0] = 1'b0;
         else if (size != SIZE_BYTE) a[1:0] = 2'b00;
      end
      return a;
   endfunction

   function automatic mbad_req_type random_bus_access();
      mbad_req_type item;
      int unsigned  roll;
      roll = $urandom_range(0, 99);
      if (roll < 42) item.req_type = REQ_READ;
      else if (roll < 74) item.req_type = REQ_WRITE;
      else if (roll < 97) item.req_type = REQ_PRELOAD;
      else item.req_type = REQ_ODD;
      if ($urandom_range(0, 99) < 3) item.access_size = SIZE_ODD;
      else item.access_size = 2'($urandom_range(0, 2));
      item.address = pick_address(item.access_size);
      item.write_data = $urandom();
      // a read of unfilled store bytes becomes a write or preload instead
      if (!reads_defined(item))
         item.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_PRELOAD;
      return item;
   endfunction

   function automatic script_step_type plain_step(logic [1:0] kind, logic [1:0] size,
                                                  logic [31:0] addr, logic [31:0] data);
      script_step_type s;
      s = '0;
      s.access.req_type = kind;
      s.access.access_size = size;
      s.access.address = addr;
      s.access.write_data = data;
      return s;
   endfunction

   function automatic script_step_type checked_step(logic [1:0] kind, logic [1:0] size,
                                                    logic [31:0] addr, logic [31:0] data,
                                                    logic [31:0] rdata, logic [1:0] status);
      script_step_type s;
      s = plain_step(kind, size, addr, data);
      s.typed = 1'b1;
      s.want.read_data = rdata;
      s.want.status = status;
      return s;
   endfunction

   function automatic script_step_type csr_step(logic [CSR_IDX_W-1:0] sel,
                                                logic [31:0] value);
      script_step_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.csr_sel = sel;
      s.csr_value = value;
      return s;
   endfunction

   // drives one item until it is taken, then books its result; valid is lowered only by a random gap or by the caller
   task automatic send_access(input mbad_req_type item, input bit typed,
                              input mbad_rsp_type typed_rsp);
      mbad_rsp_type predicted;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = decode_bus_access(item);
      pending_bus_results.push_back(typed ? typed_rsp : predicted);
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // sender holds off until every booked result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_bus_results.size() != 0) @(posedge clock);
   endtask

   // leaves csr_we high so back-to-back writes need no toggle; the caller lowers it
   task automatic write_register(input logic [CSR_IDX_W-1:0] sel, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      case (sel)
         CSR_RAM_START:   windows.ram_start = value;
         CSR_ROM_START:   windows.rom_start = value;
         CSR_UART_START:  windows.uart_start = value;
         CSR_TIMER_START: windows.timer_start = value;
         CSR_DISK_START:  windows.disk_start = value;
         CSR_UART_BYTES:  windows.uart_bytes = value[SIZE_REG_W-1:0];
         CSR_TIMER_BYTES: windows.timer_bytes = value[SIZE_REG_W-1:0];
         CSR_DISK_BYTES:  windows.disk_bytes = value[SIZE_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_windows(input mbad_cfg_type setting);
      write_register(CSR_RAM_START, setting.ram_start);
      write_register(CSR_ROM_START, setting.rom_start);
      write_register(CSR_UART_START, setting.uart_start);
      write_register(CSR_TIMER_START, setting.timer_start);
      write_register(CSR_DISK_START, setting.disk_start);
      write_register(CSR_UART_BYTES, 32'(setting.uart_bytes));
      write_register(CSR_TIMER_BYTES, 32'(setting.timer_bytes));
      write_register(CSR_DISK_BYTES, 32'(setting.disk_bytes));
      csr_we <= 1'b0;
   endtask

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < 50)
         $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- result side

   // receiver stalls at random, at the rate the current phase sets
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // compare each taken result with the oldest booked one; watchdog on handshakes
   always @(posedge clock) begin : watch_results
      mbad_rsp_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_bus_results.size() == 0) begin
               flag_mismatch("result with nothing pending", rsp_payload.read_data, 32'd0);
            end else begin
               want = pending_bus_results.pop_front();
               if (rsp_payload.read_data !== want.read_data)
                  flag_mismatch("read_data", rsp_payload.read_data, want.read_data);
               if (rsp_payload.status !== want.status)
                  flag_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : run_stimulus
      script_step_type steps [SCRIPT_LEN];
      mbad_cfg_type    setting;
      int unsigned     issued;
      windows = '{RST_RAM_START, RST_ROM_START, RST_UART_START, RST_TIMER_START,
                  RST_DISK_START, RST_PER_BYTES, RST_PER_BYTES, RST_PER_BYTES};
      issued = 0;

      // directed part, starting from the reset windows
      steps = '{
         // ram extremes: first word and last byte
         checked_step(REQ_WRITE, SIZE_WORD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, ST_OK),
         checked_step(REQ_READ, SIZE_WORD, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, ST_OK),
         checked_step(REQ_WRITE, SIZE_BYTE, 32'h0000_FFFF, 32'hFFFF_FF00, 32'h0, ST_OK),
         checked_step(REQ_READ, SIZE_BYTE, 32'h0000_FFFF, 32'h0, 32'h0, ST_OK),
         // misaligned halfword and word
         checked_step(REQ_WRITE, SIZE_HALF, 32'h0000_0001, 32'h1234_5678, 32'h0, ST_ALIGN),
         checked_step(REQ_READ, SIZE_WORD, 32'h0000_0002, 32'h0, 32'h0, ST_ALIGN),
         // just past the ram window is unmapped
         checked_step(REQ_READ, SIZE_BYTE, 32'h0001_0000, 32'h0, 32'h0, ST_BUS),
         // rom preload and read back, write to rom and preload outside rom refused
         checked_step(REQ_PRELOAD, SIZE_WORD, 32'h1000_0000, 32'hA5C3_5A3C, 32'h0, ST_OK),
         checked_step(REQ_READ, SIZE_WORD, 32'h1000_0000, 32'h0, 32'hA5C3_5A3C, ST_OK),
         checked_step(REQ_WRITE, SIZE_BYTE, 32'h1000_0000, 32'h0000_00FF, 32'h0, ST_BUS),
         checked_step(REQ_PRELOAD, SIZE_WORD, 32'h0000_0000, 32'h0BAD_0BAD, 32'h0, ST_BUS),
         checked_step(REQ_PRELOAD, SIZE_HALF, 32'h1000_FFFE, 32'h0000_1234, 32'h0, ST_OK),
         checked_step(REQ_READ, SIZE_HALF, 32'h1000_FFFE, 32'h0, 32'h0000_1234, ST_OK),
         // peripherals read zero and swallow writes; edges of timer and disk
         checked_step(REQ_WRITE, SIZE_WORD, 32'h2000_0000, 32'hDEAD_BEEF, 32'h0, ST_OK),
         checked_step(REQ_READ, SIZE_WORD, 32'h2000_00FC, 32'h0, 32'h0, ST_OK),
         checked_step(REQ_READ, SIZE_BYTE, 32'h2000_10FF, 32'h0, 32'h0, ST_OK),
         checked_step(REQ_READ, SIZE_BYTE, 32'h2000_1100, 32'h0, 32'h0, ST_BUS),
         checked_step(REQ_WRITE, SIZE_HALF, 32'h2000_2000, 32'h0000_FFFF, 32'h0, ST_OK),
         // unknown type reads, unknown size acts as a word; the top word of memory is unmapped
         checked_step(REQ_ODD, SIZE_WORD, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, ST_OK),
         checked_step(REQ_READ, SIZE_ODD, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, ST_OK),
         checked_step(REQ_READ, SIZE_ODD, 32'h0000_0002, 32'h0, 32'h0, ST_ALIGN),
         checked_step(REQ_READ, SIZE_WORD, 32'hFFFF_FFFC, 32'h0, 32'h0, ST_BUS),
         // unaligned ram base: a word write runs off the end, the first two bytes stick
         csr_step(CSR_RAM_START, 32'h0000_0002),
         checked_step(REQ_WRITE, SIZE_WORD, 32'h0001_0000, 32'hCAFE_F00D, 32'h0, ST_BUS),
         plain_step(REQ_READ, SIZE_HALF, 32'h0001_0000, 32'h0),
         // same for a preload off the end of a shifted rom window
         csr_step(CSR_ROM_START, 32'h1000_0002),
         checked_step(REQ_PRELOAD, SIZE_WORD, 32'h1001_0000, 32'h8BAD_F00D, 32'h0, ST_BUS),
         // the partial preload must have left its two bytes readable
         plain_step(REQ_READ, SIZE_HALF, 32'h1001_0000, 32'h0),
         checked_step(REQ_READ, SIZE_WORD, 32'h1001_0000, 32'h0, 32'h0, ST_BUS)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct = 31;
      rsp_stall_pct = 45;
      foreach (steps[k]) begin
         if (steps[k].is_csr) begin
            drain_results();
            write_register(steps[k].csr_sel, steps[k].csr_value);
            csr_we <= 1'b0;
         end else begin
            send_access(steps[k].access, steps[k].typed, steps[k].want);
         end
      end

      // random part: one window layout per phase, written while the block is empty
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: setting = '{RST_RAM_START, RST_ROM_START, RST_UART_START, RST_TIMER_START,
                           RST_DISK_START, RST_PER_BYTES, RST_PER_BYTES, RST_PER_BYTES};
            // high ram and rom, smallest uart at address zero
            1: setting = '{32'hFFFE_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0001,
                           32'h0001_0001, 17'd1, 17'd65536, 17'd65536};
            // rom half hidden under ram, uart clipped at the top, odd small windows
            2: setting = '{32'h0000_0000, 32'h0000_8000, 32'hFFFF_FF00, 32'h8000_0003,
                           32'h7FFF_FFFE, 17'd65536, 17'd5, 17'd3};
            3: begin
               setting.ram_start = $urandom();
               setting.rom_start = $urandom();
               setting.uart_start = $urandom();
               setting.timer_start = $urandom();
               setting.disk_start = $urandom();
               setting.uart_bytes = 17'($urandom_range(1, 65536));
               setting.timer_bytes = 17'($urandom_range(1, 65536));
               setting.disk_bytes = 17'($urandom_range(1, 65536));
            end
            // windows packed close together so they overlap and abut
            4: begin
               setting.ram_start = 32'h4000_0000 + $urandom_range(0, 32'h3_0000);
               setting.rom_start = 32'h4000_0000 + $urandom_range(0, 32'h3_0000);
               setting.uart_start = 32'h4000_0000 + $urandom_range(0, 32'h3_0000);
               setting.timer_start = 32'h4000_0000 + $urandom_range(0, 32'h3_0000);
               setting.disk_start = 32'h4000_0000 + $urandom_range(0, 32'h3_0000);
               setting.uart_bytes = 17'($urandom_range(1, 65536));
               setting.timer_bytes = 17'($urandom_range(1, 65536));
               setting.disk_bytes = 17'($urandom_range(1, 65536));
            end
            // odd ram base, two-byte rom clipped at the top of memory
            default: setting = '{32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFE_0000, 32'h0000_0000,
                                 32'h0001_FFFF, 17'd65536, 17'd65536, 17'd2};
         endcase
         drain_results();
         load_windows(setting);
         for (int n = 0; n < PER_PHASE; n++) begin
            // receiver-heavy idling, then sender-heavy, then none at all
            if (issued < PHASES * PER_PHASE / 3) begin
               req_gap_pct = 31;
               rsp_stall_pct = 45;
            end else if (issued < 2 * PHASES * PER_PHASE / 3) begin
               req_gap_pct = 45;
               rsp_stall_pct = 31;
            end else begin
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
            send_access(random_bus_access(), 1'b0, '0);
            issued++;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
